// ===== src/swdc_pkg.sv =====
// Shared definitions for the sliding window distinct counter.
// Holds field widths, parameter defaults, queue sizing and the control state type.
// No dependencies.
package swdc_pkg;

  localparam int SAMPLE_W = 12;       // width of the sample input field
  localparam int COUNT_W = 9;         // width of window size and distinct count
  localparam int CNT_W = 9;           // width of one occurrence counter
  localparam int WINDOW_MAX_DEF = 256;
  localparam int VALUE_BITS_DEF = 12;

  // Result queue: four entries cover the results in flight in the counter path plus the consumer turnaround.
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAVE,
    ST_ENTER
  } swdc_state_t;

endpackage

// ===== src/sliding_window_distinct_count.sv =====
// Top level of the sliding window distinct counter.
// Holds the sample ring, the occurrence counter memory and the control sequencer.
// Depends on swdc_pkg.
//
// Usage: each input transaction carries one sample; after the window has filled,
// each input transaction yields one output transaction carrying the number of
// distinct values among the last window_size samples. While the window is still
// filling, no result is produced. The configuration channel takes a window_size
// (0 acts as 1, values above WINDOW_MAX saturate) and restarts the sequence; it is
// always ready and should only be written while the block is idle.
// Each sample needs up to two read-modify-write updates of the occurrence counter
// memory (the leaving value once the window is full, then the entering value), and
// that memory has a single read port; the next sample is accepted during the entering update.
// A result is formed after the leave and enter steps and the counter read stage.
// Reset and every configuration write start a clearing pass that zeroes the counter
// memory one entry per cycle over all 2**VALUE_BITS entries (4096 by default); no
// sample is accepted during it. Results wait in a four-entry queue, so a stalled
// receiver does not block input until that queue is committed; input then pauses
// until the receiver drains it. Nothing is lost or duplicated under stalls.
module sliding_window_distinct_count #(
  parameter int WINDOW_MAX = swdc_pkg::WINDOW_MAX_DEF,
  parameter int VALUE_BITS = swdc_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swdc_pkg::SAMPLE_W-1:0] sample_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swdc_pkg::COUNT_W-1:0]  distinct_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swdc_pkg::COUNT_W-1:0]  window_size
);
  import swdc_pkg::*;

  localparam int RING_AW = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int VDEPTH = 2 ** VALUE_BITS;

  // One counter memory operation travelling from the read stage to the write stage.
  typedef struct packed {
    logic                  valid;
    logic                  enter;
    logic                  emit;
    logic [VALUE_BITS-1:0] addr;
  } cnt_op_t;

  swdc_state_t state, state_next;

  logic in_fire, out_fire, cfg_fire;
  logic [KW-1:0] win_len;
  logic [KW-1:0] fill_level;
  logic [RING_AW-1:0] ring_position;
  logic [CNT_W-1:0] distinct_total;
  logic [VALUE_BITS-1:0] clr_addr;

  // Sample held between acceptance and its two counter operations.
  logic [VALUE_BITS-1:0] s_value;
  logic s_leave, s_emit;

  logic [VALUE_BITS-1:0] ring_mem [WINDOW_MAX];
  logic [VALUE_BITS-1:0] ring_rdata;
  logic [CNT_W-1:0] cnt_mem [VDEPTH];
  logic [CNT_W-1:0] cnt_rdata;

  cnt_op_t issue, op;
  logic fwd_valid;
  logic [VALUE_BITS-1:0] fwd_addr;
  logic [CNT_W-1:0] fwd_data;

  logic [COUNT_W-1:0] q_mem [QDEPTH];
  logic [QAW-1:0] q_wr, q_rd;
  logic [QAW:0] q_count, pend;

  logic [VALUE_BITS-1:0] sample_val;
  logic [RING_AW-1:0] pos_eff, pos_next;
  logic [KW-1:0] pos_plus, fill_inc;
  logic win_full, win_emit;

  logic op_write, q_push;
  logic [CNT_W-1:0] cnt_cur, cnt_new, total_upd;

  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;

  // A new sample may enter while the previous one is issuing its entering update,
  // provided the result queue still has an uncommitted slot.
  assign in_ready = (state == ST_IDLE || state == ST_ENTER) && (pend < (QAW + 1)'(QDEPTH));

  // Window bookkeeping for the sample being accepted.
  assign sample_val = VALUE_BITS'(sample_value);
  assign pos_eff = (KW'(ring_position) >= win_len) ? '0 : ring_position;
  assign pos_plus = KW'(pos_eff) + KW'(1);
  assign pos_next = (pos_plus >= win_len) ? '0 : RING_AW'(pos_plus);
  assign win_full = fill_level >= win_len;
  assign fill_inc = fill_level + KW'(1);
  assign win_emit = win_full || (fill_inc == win_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue = '0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == {VALUE_BITS{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_LEAVE;
        end
      end
      ST_LEAVE: begin
        issue.valid = s_leave;
        issue.enter = 1'b0;
        issue.emit = 1'b0;
        issue.addr = ring_rdata;
        state_next = ST_ENTER;
      end
      ST_ENTER: begin
        issue.valid = 1'b1;
        issue.enter = 1'b1;
        issue.emit = s_emit;
        issue.addr = s_value;
        state_next = in_fire ? ST_LEAVE : ST_IDLE;
      end
    endcase
    if (cfg_fire) begin
      state_next = ST_CLEAR;
    end
  end

  // Window length, sequence position, fill level and clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= KW'(1);
      fill_level <= '0;
      ring_position <= '0;
      clr_addr <= '0;
    end else if (cfg_fire) begin
      if (window_size == '0) begin
        win_len <= KW'(1);
      end else if (int'(window_size) > WINDOW_MAX) begin
        win_len <= KW'(WINDOW_MAX);
      end else begin
        win_len <= KW'(window_size);
      end
      fill_level <= '0;
      ring_position <= '0;
      clr_addr <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + VALUE_BITS'(1);
      end
      if (in_fire) begin
        ring_position <= pos_next;
        if (!win_full) begin
          fill_level <= fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_value <= sample_val;
      s_leave <= win_full;
      s_emit <= win_emit;
    end
  end

  // Sample ring: the old sample at this position is read as the new one is written.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring_mem[pos_eff] <= sample_val;
      ring_rdata <= ring_mem[pos_eff];
    end
  end

  // Counter read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= '0;
    end else begin
      op <= issue;
    end
  end

  // Counter modify stage. Back-to-back operations on one value take the value
  // just written from the forwarding register instead of the stale read.
  assign op_write = op.valid && (state != ST_CLEAR);
  assign cnt_cur = (fwd_valid && fwd_addr == op.addr) ? fwd_data : cnt_rdata;

  always_comb begin
    cnt_new = cnt_cur;
    total_upd = distinct_total;
    if (op.enter) begin
      if (cnt_cur == '0) begin
        total_upd = distinct_total + CNT_W'(1);
      end
      if (cnt_cur != {CNT_W{1'b1}}) begin
        cnt_new = cnt_cur + CNT_W'(1);
      end
    end else if (cnt_cur != '0) begin
      cnt_new = cnt_cur - CNT_W'(1);
      if (cnt_cur == CNT_W'(1) && distinct_total != '0) begin
        total_upd = distinct_total - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      cnt_mem[clr_addr] <= '0;
    end else if (op_write) begin
      cnt_mem[op.addr] <= cnt_new;
    end
    cnt_rdata <= cnt_mem[issue.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      distinct_total <= '0;
    end else begin
      fwd_valid <= op_write;
      if (cfg_fire) begin
        distinct_total <= '0;
      end else if (op_write) begin
        distinct_total <= total_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= op.addr;
    fwd_data <= cnt_new;
  end

  // Result queue. pend counts results promised to the receiver, queued or in flight.
  assign q_push = op_write && op.enter && op.emit;
  assign out_valid = q_count != '0;
  assign distinct_count = COUNT_W'(q_mem[q_rd]);

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr] <= COUNT_W'(total_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr <= '0;
      q_rd <= '0;
      q_count <= '0;
      pend <= '0;
    end else begin
      if (q_push) begin
        q_wr <= q_wr + QAW'(1);
      end
      if (out_fire) begin
        q_rd <= q_rd + QAW'(1);
      end
      q_count <= q_count + (QAW + 1)'(q_push) - (QAW + 1)'(out_fire);
      pend <= pend + (QAW + 1)'(in_fire && win_emit) - (QAW + 1)'(out_fire);
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QAW + 1)'(QDEPTH))
    else $error("result queue holds more entries than it has");

  a_queue_within_pending: assert property (@(posedge clk) disable iff (rst)
    q_count <= pend)
    else $error("queued results exceed promised results");

  a_emit_on_enter: assert property (@(posedge clk) disable iff (rst)
    op.valid && op.emit |-> op.enter)
    else $error("result attached to a leaving update");

  a_accept_to_leave: assert property (@(posedge clk) disable iff (rst)
    in_fire && !cfg_fire |=> state == ST_LEAVE)
    else $error("accepted sample did not start its leaving update");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !q_push)
    else $error("result produced during the clearing pass");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_distinct_count.
// Drives samples and window_size writes, predicts each distinct count, checks every result.
// Depends on swdc_pkg and the sliding_window_distinct_count RTL.
module tb;
  import swdc_pkg::*;

  localparam int WINDOW_MAX = WINDOW_MAX_DEF;
  localparam int VALUE_BITS = VALUE_BITS_DEF;

  // Cycles allowed to pass with no transaction on any channel. The longest
  // legitimate quiet stretch is the clearing pass after reset or after a
  // window_size write, so this leaves a wide margin.
  localparam int STALL_LIMIT = 20000;
  // Cycles to let the pipeline settle once no result is outstanding. Samples
  // that only fill the window produce nothing we could wait for.
  localparam int SETTLE_CYCLES = 10;
  // Length of the deliberate receiver hold-off that backs up the result queue.
  localparam int HOLD_CYCLES = 300;

  // How the two sides pace themselves during a phase.
  typedef enum logic [1:0] {
    PACE_RX_LAGS,    // sender idles 36% of cycles, receiver 74%
    PACE_TX_LAGS,    // sender idles 74% of cycles, receiver 36%
    PACE_FULL_RATE   // neither side idles
  } pacing_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WINDOW
  } row_kind_t;

  // One row of the directed stimulus. When typed is set, count is the result
  // that the sample must produce; otherwise the predictor supplies it.
  typedef struct packed {
    row_kind_t             kind;
    logic [SAMPLE_W-1:0]   value;
    bit                    typed;
    logic [COUNT_W-1:0]    count;
  } stim_row_t;

  // One phase of the random part: the window to program, the number of
  // samples, the largest value drawn, whether values mostly count upward
  // (so most samples in the window are distinct), the pacing, and whether the
  // receiver takes a long break halfway through.
  typedef struct packed {
    logic [COUNT_W-1:0]    window;
    logic [15:0]           items;
    logic [SAMPLE_W-1:0]   value_hi;
    bit                    stepping;
    pacing_t               pacing;
    bit                    long_hold;
  } phase_t;

  // Directed rows. The block comes out of reset with a window of one, so every
  // sample there is a result of one. A window of zero must behave as one.
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{ROW_SAMPLE, 12'd0,    1'b1, 9'd1},
    '{ROW_SAMPLE, 12'd4095, 1'b1, 9'd1},
    '{ROW_SAMPLE, 12'd4095, 1'b1, 9'd1},
    '{ROW_WINDOW, 12'd2,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd5,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd5,    1'b1, 9'd1},
    '{ROW_SAMPLE, 12'd7,    1'b1, 9'd2},
    '{ROW_SAMPLE, 12'd7,    1'b0, 9'd0},
    '{ROW_WINDOW, 12'd0,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b1, 9'd1},
    '{ROW_SAMPLE, 12'd0,    1'b1, 9'd1},
    '{ROW_WINDOW, 12'd3,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd1,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd2,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd3,    1'b1, 9'd3},
    '{ROW_SAMPLE, 12'd1,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd1,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd1,    1'b1, 9'd1},
    '{ROW_WINDOW, 12'd4,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd0,    1'b1, 9'd2},
    '{ROW_SAMPLE, 12'd2730, 1'b0, 9'd0},
    '{ROW_SAMPLE, 12'd1365, 1'b0, 9'd0}
  };

  // Random phases. A window_size of 511 saturates to WINDOW_MAX; with values
  // counting upward that window comes close to the largest possible distinct count.
  localparam phase_t PHASE_PLAN [6] = '{
    '{9'd5,   16'd150, 12'd7,    1'b0, PACE_RX_LAGS,   1'b0},
    '{9'd1,   16'd40,  12'd4095, 1'b0, PACE_RX_LAGS,   1'b0},
    '{9'd511, 16'd280, 12'd4095, 1'b1, PACE_TX_LAGS,   1'b0},
    '{9'd256, 16'd280, 12'd4095, 1'b0, PACE_TX_LAGS,   1'b0},
    '{9'd8,   16'd100, 12'd15,   1'b0, PACE_FULL_RATE, 1'b1},
    '{9'd37,  16'd100, 12'd63,   1'b0, PACE_FULL_RATE, 1'b0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COUNT_W-1:0]  distinct_count;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  window_size = '0;

  always #1 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  sliding_window_distinct_count dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .distinct_count (distinct_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .window_size    (window_size)
  );

  // ---------------------------------------------------------------------------
  // Window model. It mirrors the block's own bookkeeping: a ring of the samples
  // currently in the window, an occurrence count per value, the number of
  // values whose count is nonzero, how far the window has filled, and where the
  // next sample lands in the ring.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] window_ring [WINDOW_MAX];
  logic [CNT_W-1:0]    value_occurrences [1 << VALUE_BITS];
  int unsigned         distinct_now;
  int unsigned         samples_held;
  int unsigned         ring_slot;
  int unsigned         window_len;

  // Expected distinct counts, oldest first.
  logic [COUNT_W-1:0]  pending_counts [$];

  int unsigned         error_count = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         hold_requests = 0;

  // Programming the window restarts the sequence. Zero acts as one and
  // anything above WINDOW_MAX is clipped to it.
  function automatic void restart_window(input logic [COUNT_W-1:0] size);
    if (size == 0) begin
      window_len = 1;
    end else if (size > WINDOW_MAX) begin
      window_len = WINDOW_MAX;
    end else begin
      window_len = int'(size);
    end
    foreach (window_ring[k]) window_ring[k] = '0;
    foreach (value_occurrences[k]) value_occurrences[k] = '0;
    distinct_now = 0;
    samples_held = 0;
    ring_slot = 0;
  endfunction

  // Pushes one sample through the window. Returns 1 with the new distinct
  // count once the window is full, 0 while it is still filling.
  function automatic bit track_window(input logic [SAMPLE_W-1:0] v,
                                      output logic [COUNT_W-1:0] count);
    int unsigned         slot;
    logic [SAMPLE_W-1:0] leaving;
    slot = (ring_slot >= window_len) ? 0 : ring_slot;
    count = '0;
    // With the window full, the oldest sample sits in this slot and drops out.
    if (samples_held >= window_len) begin
      leaving = window_ring[slot];
      if (value_occurrences[leaving] != 0) begin
        value_occurrences[leaving] = value_occurrences[leaving] - 1'b1;
        if (value_occurrences[leaving] == 0 && distinct_now != 0) begin
          distinct_now = distinct_now - 1;
        end
      end
    end
    window_ring[slot] = v;
    if (value_occurrences[v] == 0) begin
      distinct_now = distinct_now + 1;
    end
    if (value_occurrences[v] != '1) begin
      value_occurrences[v] = value_occurrences[v] + 1'b1;
    end
    ring_slot = (slot + 1 >= window_len) ? 0 : slot + 1;
    count = distinct_now[COUNT_W-1:0];
    if (samples_held < window_len) begin
      samples_held = samples_held + 1;
      if (samples_held < window_len) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Appends the count that a later result transaction must carry.
  function automatic void expect_result(input logic [COUNT_W-1:0] c);
    pending_counts = {pending_counts, c};
  endfunction

  // Only the first ten failures are described; the rest are just counted.
  task automatic report_error(input string what);
    if (error_count < 10) begin
      $display("%s", what);
    end
    error_count++;
  endtask

  // The sender's pace is used only by the stimulus process; the receiver's is
  // read at the clock edge by its own process, so it changes with the edge.
  task automatic set_pacing(input pacing_t pacing);
    case (pacing)
      PACE_RX_LAGS: begin
        send_idle_pct = 36;
        recv_idle_pct <= 74;
      end
      PACE_TX_LAGS: begin
        send_idle_pct = 74;
        recv_idle_pct <= 36;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
    endcase
  endtask

  // Offers one sample, after a random idle gap, and holds it until the block
  // takes it. The expectation is recorded at the edge of the transaction.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit typed,
                             input logic [COUNT_W-1:0] typed_count);
    logic [COUNT_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    do @(posedge clk); while (!in_ready);
    if (track_window(v, predicted)) begin
      expect_result(typed ? typed_count : predicted);
    end
  endtask

  // Writes window_size while the block is idle: every expected result must
  // have arrived, and the last samples, which may have produced nothing, are
  // given time to finish before the write.
  task automatic write_window(input logic [COUNT_W-1:0] size);
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    window_size <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    restart_window(size);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. It normally drops ready at random; when the stimulus asks for a
  // hold-off it keeps ready low until the HOLD_CYCLES countdown runs out, which fills the block's
  // result queue and must stall the input side without losing anything.
  // ---------------------------------------------------------------------------
  int unsigned holds_taken = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (holds_taken != hold_requests) begin
      holds_taken <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog. Every result transaction is matched with the
  // oldest expectation. The watchdog ends the run when the quiet stretch with
  // no transaction of any kind reaches STALL_LIMIT.
  // ---------------------------------------------------------------------------
  int unsigned        quiet_cycles = 0;
  logic [COUNT_W-1:0] wanted;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_counts.size() == 0) begin
          report_error($sformatf("unexpected result: distinct_count %0d with nothing pending",
                                 distinct_count));
        end else begin
          wanted = pending_counts.pop_front();
          if (distinct_count !== wanted) begin
            report_error($sformatf("distinct_count mismatch: expected %0d, got %0d",
                                   wanted, distinct_count));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_counts.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed rows first, then the random phases.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned         i;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] v;
    restart_window(9'd1);
    set_pacing(PACE_RX_LAGS);
    while (rst) @(posedge clk);

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_WINDOW) begin
        write_window(DIRECTED_ROWS[r].value[COUNT_W-1:0]);
      end else begin
        send_sample(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].count);
      end
    end

    foreach (PHASE_PLAN[p]) begin
      set_pacing(PHASE_PLAN[p].pacing);
      write_window(PHASE_PLAN[p].window);
      base = SAMPLE_W'($urandom_range(4095));
      for (i = 0; i < PHASE_PLAN[p].items; i++) begin
        // Halfway through a pressure phase the receiver stops for a while
        // while samples keep coming.
        if (PHASE_PLAN[p].long_hold && i == PHASE_PLAN[p].items / 2) begin
          hold_requests <= hold_requests + 1;
        end
        // Stepping phases count upward with an occasional random value mixed in.
        if (PHASE_PLAN[p].stepping && $urandom_range(7) != 0) begin
          v = base + i[SAMPLE_W-1:0];
        end else begin
          v = SAMPLE_W'($urandom_range(PHASE_PLAN[p].value_hi));
        end
        send_sample(v, 1'b0, '0);
      end
    end

    // Drain: all results in, then a quiet settling wait to catch any extra one.
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
